[rtl/kpde_pkg.sv]
// ----------------------------------------------------------------------------
// kpde_pkg
// Shared types, constants and the key decode function for the keypad
// scanner with decimal entry.
// ----------------------------------------------------------------------------
package kpde_pkg;

  localparam int ROW_W    = 3;
  localparam int COL_N    = 4;
  localparam int COL_W    = 2;
  localparam int CODE_W   = 7;
  localparam int CHAR_W   = 7;
  localparam int TICK_W   = 16;
  localparam int NUM_W    = 16;
  localparam int DCNT_W   = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int KEY_N    = 12;

  localparam logic [DCNT_W-1:0] MAX_DIGITS = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd1;

  localparam logic [TICK_W-1:0] SETTLE_RST   = 16'd5;
  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd50;

  localparam logic [ROW_W-1:0]  NO_KEY    = 3'h7;
  localparam logic [CHAR_W-1:0] CHAR_STAR = 7'h2A;
  localparam logic [CHAR_W-1:0] CHAR_HASH = 7'h23;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 7'd57;
  localparam logic [CHAR_W-1:0] CHAR_NONE = 7'd0;

  localparam logic [CODE_W-1:0] KEY_CODES [KEY_N] = '{
    7'h45, 7'h0E, 7'h0D, 7'h0B, 7'h16, 7'h15,
    7'h13, 7'h26, 7'h25, 7'h23, 7'h46, 7'h43
  };

  typedef struct packed {
    logic [COL_N-1:0]  column_drive;
    logic              echo_valid;
    logic [CHAR_W-1:0] echo_char;
    logic              number_valid;
    logic [NUM_W-1:0]  number;
  } kpde_res_t;

  // Maps a key code to its ASCII character, or to zero for an unknown code.
  function automatic logic [CHAR_W-1:0] decode_key(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    c = CHAR_NONE;
    for (int k = KEY_N - 1; k >= 0; k--) begin
      if (KEY_CODES[k] == code) begin
        if (k == 10) begin
          c = CHAR_STAR;
        end else if (k == 11) begin
          c = CHAR_HASH;
        end else begin
          c = CHAR_ZERO + CHAR_W'(k);
        end
      end
    end
    return c;
  endfunction

endpackage

[rtl/keypad_scan_decimal_entry_unit.sv]
// The result of a tick beat is registered into the output stage, or into the buffer when the output is stalled.
// Throughput: one tick beat per cycle while in_stall is low; the scan state is updated on each accepted beat.
// A two-entry output buffer lets a beat be accepted while a result waits.
// Reset: synchronous, active low; restores scanning at the first column,
// clears counters and accumulator, and loads settle 5 and debounce 50.
// ----------------------------------------------------------------------------
// keypad_scan_decimal_entry_unit
// Scans a 4x3 keypad one tick per beat, debounces each press, decodes it and
// collects a decimal number that is given on hash or at the last digit.
// ----------------------------------------------------------------------------
module keypad_scan_decimal_entry_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [kpde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpde_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kpde_pkg::ROW_W-1:0]      in_row_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kpde_pkg::COL_N-1:0]      out_column_drive,
  output logic                            out_echo_valid,
  output logic [kpde_pkg::CHAR_W-1:0]     out_echo_char,
  output logic                            out_number_valid,
  output logic [kpde_pkg::NUM_W-1:0]      out_number
);
  import kpde_pkg::*;

  localparam logic [1:0] PH_SCAN     = 2'd0;
  localparam logic [1:0] PH_RELEASE  = 2'd1;
  localparam logic [1:0] PH_DEBOUNCE = 2'd2;

  logic [TICK_W-1:0] settle_r, debounce_r;
  logic [1:0]        phase_r, phase_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;

  kpde_res_t out_r, skid_r, res;
  logic      out_valid_r, skid_valid_r;

  logic              in_acc, out_take;
  logic [COL_N-1:0]  drive;
  logic [TICK_W:0]   cnt;
  logic              decode_now;
  logic [CHAR_W-1:0] key_char;
  logic [NUM_W-1:0]  acc_digit;
  logic [DCNT_W-1:0] dcnt_inc;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  assign drive     = COL_N'(1) << col_r;
  assign cnt       = {1'b0, tick_r} + 17'd1;
  assign key_char  = decode_key(code_r);
  assign acc_digit = (acc_r << 3) + (acc_r << 1) + NUM_W'(key_char - CHAR_ZERO);
  assign dcnt_inc  = dcnt_r + 3'd1;

  always_comb begin
    phase_nxt  = phase_r;
    col_nxt    = col_r;
    tick_nxt   = tick_r;
    code_nxt   = code_r;
    dcnt_nxt   = dcnt_r;
    acc_nxt    = acc_r;
    decode_now = 1'b0;
    res              = '0;
    res.column_drive = drive;

    case (phase_r)
      PH_RELEASE: begin
        if (in_row_sample == NO_KEY) begin
          if (debounce_r == '0) begin
            decode_now = 1'b1;
          end else begin
            phase_nxt = PH_DEBOUNCE;
            tick_nxt  = '0;
          end
        end
      end
      PH_DEBOUNCE: begin
        if (cnt >= {1'b0, debounce_r}) begin
          decode_now = 1'b1;
        end else begin
          tick_nxt = cnt[TICK_W-1:0];
        end
      end
      default: begin
        phase_nxt = PH_SCAN;
        if (cnt >= {1'b0, settle_r}) begin
          tick_nxt = '0;
          if (in_row_sample != NO_KEY) begin
            code_nxt  = {drive, in_row_sample};
            phase_nxt = PH_RELEASE;
          end else begin
            col_nxt = col_r + 2'd1;
          end
        end else begin
          tick_nxt = cnt[TICK_W-1:0];
        end
      end
    endcase

    if (decode_now) begin
      phase_nxt = PH_SCAN;
      tick_nxt  = '0;
      col_nxt   = col_r + 2'd1;
      if (key_char >= CHAR_ZERO && key_char <= CHAR_NINE) begin
        res.echo_valid = 1'b1;
        res.echo_char  = key_char;
        acc_nxt        = acc_digit;
        dcnt_nxt       = dcnt_inc;
        if (dcnt_inc >= MAX_DIGITS) begin
          res.number_valid = 1'b1;
          res.number       = acc_digit;
          acc_nxt          = '0;
          dcnt_nxt         = '0;
        end
      end else if (key_char == CHAR_HASH) begin
        res.number_valid = 1'b1;
        res.number       = acc_r;
        acc_nxt          = '0;
        dcnt_nxt         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r   <= SETTLE_RST;
      debounce_r <= DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE:   settle_r   <= cfg_data;
        CFG_DEBOUNCE: debounce_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SCAN;
      col_r   <= '0;
      tick_r  <= '0;
      code_r  <= '0;
      dcnt_r  <= '0;
      acc_r   <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      tick_r  <= tick_nxt;
      code_r  <= code_nxt;
      dcnt_r  <= dcnt_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc) begin
        out_r <= res;
      end
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column_drive = out_r.column_drive;
  assign out_echo_valid   = out_r.echo_valid;
  assign out_echo_char    = out_r.echo_char;
  assign out_number_valid = out_r.number_valid;
  assign out_number       = out_r.number;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("Buffered result present while output stage is empty.");

  a_drive_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(out_r.column_drive))
    else $error("Column drive is not one-hot.");

  a_echo_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.echo_valid) |->
      (out_r.echo_char >= CHAR_ZERO && out_r.echo_char <= CHAR_NINE))
    else $error("Echoed character is not a digit.");

  a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r < MAX_DIGITS)
    else $error("Digit count reached the entry limit without finishing.");
`endif

endmodule

[tb/sv/keypad_scan_decimal_entry_unit_tb.sv]
// ----------------------------------------------------------------------------
// keypad_scan_decimal_entry_unit_tb
// Drives row samples tick by tick, as a keypad would with keys pressed,
// bounced and released, and checks every result beat against a model of the
// scanner and decimal entry or fixed values, with random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keypad_scan_decimal_entry_unit_tb;
  import kpde_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int DIR_RESET_ROWS = 5;
  localparam int DIR_N = 25;
  localparam int N_PH = 6;

  typedef enum logic [1:0] {KP_SCAN, KP_RELEASE, KP_DEBOUNCE} kp_phase_t;

  typedef struct packed {
    logic [ROW_W-1:0] rows;
    logic             typed;
    kpde_res_t        known;
  } scan_vec_t;

  localparam kpde_res_t COL0_QUIET = '{4'h1, 1'b0, CHAR_NONE, 1'b0, 16'd0};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SETTLE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ROW_W-1:0]     in_row_sample = NO_KEY;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COL_N-1:0]     out_column_drive;
  logic                 out_echo_valid;
  logic [CHAR_W-1:0]    out_echo_char;
  logic                 out_number_valid;
  logic [NUM_W-1:0]     out_number;

  keypad_scan_decimal_entry_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_sample    (in_row_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_drive (out_column_drive),
    .out_echo_valid   (out_echo_valid),
    .out_echo_char    (out_echo_char),
    .out_number_valid (out_number_valid),
    .out_number       (out_number)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Scanner model state and register copies.
  kp_phase_t         kp_phase = KP_SCAN;
  logic [COL_W-1:0]  kp_col = '0;
  logic [TICK_W-1:0] kp_ticks = '0;
  logic [CODE_W-1:0] kp_code = '0;
  logic [DCNT_W-1:0] kp_digits = '0;
  logic [NUM_W-1:0]  kp_value = '0;
  logic [TICK_W-1:0] settle_reg = SETTLE_RST;
  logic [TICK_W-1:0] debounce_reg = DEBOUNCE_RST;

  kpde_res_t   pending_scans[$];
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned ticks_sent = 0;
  int unsigned beats_out = 0;
  int unsigned n_err = 0;
  int unsigned cycle_count = 0;

  scan_vec_t dir_ticks [DIR_N] = '{
    '{NO_KEY, 1'b1, COL0_QUIET},
    '{NO_KEY, 1'b1, COL0_QUIET},
    '{NO_KEY, 1'b1, COL0_QUIET},
    '{NO_KEY, 1'b1, COL0_QUIET},
    '{NO_KEY, 1'b1, COL0_QUIET},
    '{3'b110, 1'b0, '0},
    '{3'b110, 1'b0, '0},
    '{NO_KEY, 1'b0, '0},
    '{NO_KEY, 1'b0, '0},
    '{3'b110, 1'b0, '0},
    '{NO_KEY, 1'b0, '0},
    '{3'b000, 1'b0, '0},
    '{NO_KEY, 1'b0, '0},
    '{NO_KEY, 1'b0, '0},
    '{3'b011, 1'b0, '0},
    '{NO_KEY, 1'b0, '0},
    '{3'b011, 1'b0, '0},
    '{NO_KEY, 1'b1, '{4'h8, 1'b0, CHAR_NONE, 1'b1, 16'd49}},
    '{NO_KEY, 1'b0, '0},
    '{NO_KEY, 1'b0, '0},
    '{NO_KEY, 1'b0, '0},
    '{3'b011, 1'b0, '0},
    '{NO_KEY, 1'b1, '{4'h8, 1'b0, CHAR_NONE, 1'b1, 16'd0}},
    '{3'b101, 1'b0, '0},
    '{NO_KEY, 1'b0, '0}
  };

  int unsigned ph_settle [N_PH] = '{1, 3, 0, 24, 2, 1};
  int unsigned ph_bounce [N_PH] = '{0, 4, 1, 40, 2, 3};
  int unsigned ph_ticks  [N_PH] = '{220, 260, 220, 0, 260, 180};

  function automatic logic [CHAR_W-1:0] key_to_char(input logic [CODE_W-1:0] code);
    case (code)
      7'h45: return CHAR_ZERO;
      7'h0E: return CHAR_ZERO + 7'd1;
      7'h0D: return CHAR_ZERO + 7'd2;
      7'h0B: return CHAR_ZERO + 7'd3;
      7'h16: return CHAR_ZERO + 7'd4;
      7'h15: return CHAR_ZERO + 7'd5;
      7'h13: return CHAR_ZERO + 7'd6;
      7'h26: return CHAR_ZERO + 7'd7;
      7'h25: return CHAR_ZERO + 7'd8;
      7'h23: return CHAR_ZERO + 7'd9;
      7'h46: return CHAR_STAR;
      7'h43: return CHAR_HASH;
      default: return CHAR_NONE;
    endcase
  endfunction

  function automatic kpde_res_t scan_keypad_tick(input logic [ROW_W-1:0] rows);
    kpde_res_t         r;
    logic [CHAR_W-1:0] ch;
    logic              fire;
    logic [TICK_W:0]   nxt;
    r = '0;
    fire = 1'b0;
    r.column_drive = COL_N'(1) << kp_col;
    nxt = {1'b0, kp_ticks} + 1'b1;
    case (kp_phase)
      KP_RELEASE: begin
        if (rows == NO_KEY) begin
          if (debounce_reg == '0) begin
            fire = 1'b1;
          end else begin
            kp_phase = KP_DEBOUNCE;
            kp_ticks = '0;
          end
        end
      end
      KP_DEBOUNCE: begin
        if (nxt >= {1'b0, debounce_reg}) begin
          fire = 1'b1;
        end else begin
          kp_ticks = nxt[TICK_W-1:0];
        end
      end
      default: begin
        if (nxt >= {1'b0, settle_reg}) begin
          kp_ticks = '0;
          if (rows != NO_KEY) begin
            kp_code = {r.column_drive, rows};
            kp_phase = KP_RELEASE;
          end else begin
            kp_col = kp_col + 1'b1;
            kp_phase = KP_SCAN;
          end
        end else begin
          kp_ticks = nxt[TICK_W-1:0];
          kp_phase = KP_SCAN;
        end
      end
    endcase
    if (fire) begin
      ch = key_to_char(kp_code);
      kp_phase = KP_SCAN;
      kp_ticks = '0;
      kp_col = kp_col + 1'b1;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        r.echo_valid = 1'b1;
        r.echo_char = ch;
        kp_value = NUM_W'(kp_value * 10 + NUM_W'(ch - CHAR_ZERO));
        kp_digits = kp_digits + 1'b1;
        if (kp_digits >= MAX_DIGITS) begin
          r.number_valid = 1'b1;
          r.number = kp_value;
          kp_value = '0;
          kp_digits = '0;
        end
      end else if (ch == CHAR_HASH) begin
        r.number_valid = 1'b1;
        r.number = kp_value;
        kp_value = '0;
        kp_digits = '0;
      end
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] rand_rows();
    return ROW_W'($urandom_range(0, 7));
  endfunction

  task automatic drive_tick(input logic [ROW_W-1:0] rows);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row_sample <= rows;
    ticks_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_tick(input logic [ROW_W-1:0] rows);
    pending_scans.push_back(scan_keypad_tick(rows));
    drive_tick(rows);
  endtask

  task automatic drain_scans();
    in_valid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_SETTLE) begin
      settle_reg = val;
    end else begin
      debounce_reg = val;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One key stroke: wait for the scan to reach the key, hold, release, settle.
  // With pin_col set, the key sits on the column being scanned right now.
  task automatic key_press(input bit pin_col, input bit noisy);
    logic [CODE_W-1:0] code;
    logic [ROW_W-1:0]  pat;
    logic [ROW_W-1:0]  multi [4];
    logic [COL_W-1:0]  col;
    int unsigned       sel;
    int unsigned       hold;
    multi = '{3'b000, 3'b001, 3'b010, 3'b100};
    while (kp_phase != KP_SCAN) send_tick(NO_KEY);
    sel = $urandom_range(0, 19);
    if (pin_col) begin
      col = kp_col;
      pat = 3'b110;
    end else if (sel < 3) begin
      col = COL_W'($urandom_range(0, 3));
      pat = multi[$urandom_range(0, 3)];
    end else begin
      code = KEY_CODES[(sel < 6) ? 11 : $urandom_range(0, 11)];
      pat = code[ROW_W-1:0];
      col = code[4] ? 2'd1 : code[5] ? 2'd2 : code[6] ? 2'd3 : 2'd0;
    end
    while (kp_phase == KP_SCAN) begin
      if (noisy && $urandom_range(0, 24) == 0) begin
        send_tick(rand_rows());
      end else begin
        send_tick((kp_col == col) ? pat : NO_KEY);
      end
    end
    hold = $urandom_range(0, 3);
    repeat (hold) send_tick((noisy && $urandom_range(0, 3) == 0) ? rand_rows() : pat);
    while (kp_phase != KP_SCAN) begin
      if (noisy && kp_phase == KP_DEBOUNCE && $urandom_range(0, 2) == 0) begin
        send_tick(rand_rows());
      end else begin
        send_tick(NO_KEY);
      end
    end
  endtask

  always @(posedge clk) begin : check_out
    kpde_res_t got;
    kpde_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_column_drive, out_echo_valid, out_echo_char, out_number_valid, out_number};
      beats_out++;
      if (pending_scans.size() == 0) begin
        n_err++;
        if (n_err <= 10) begin
          $display("beat %0d: unexpected result, drive %h echo %b/%0d number %b/%0d",
                   beats_out, got.column_drive, got.echo_valid, got.echo_char,
                   got.number_valid, got.number);
        end
      end else begin
        want = pending_scans.pop_front();
        if (got.column_drive !== want.column_drive || got.echo_valid !== want.echo_valid ||
            got.echo_char !== want.echo_char || got.number_valid !== want.number_valid ||
            got.number !== want.number) begin
          n_err++;
          if (n_err <= 10) begin
            $display("beat %0d: want drive %h echo %b/%0d number %b/%0d", beats_out,
                     want.column_drive, want.echo_valid, want.echo_char,
                     want.number_valid, want.number);
            $display("beat %0d: got  drive %h echo %b/%0d number %b/%0d", beats_out,
                     got.column_drive, got.echo_valid, got.echo_char,
                     got.number_valid, got.number);
          end
        end
      end
    end
  end

  initial begin : stall_gen
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : main_seq
    kpde_res_t   predicted;
    int unsigned start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (i == DIR_RESET_ROWS) begin
        drain_scans();
        write_cfg(CFG_SETTLE, '0);
        write_cfg(CFG_DEBOUNCE, '0);
      end
      predicted = scan_keypad_tick(dir_ticks[i].rows);
      pending_scans.push_back(dir_ticks[i].typed ? dir_ticks[i].known : predicted);
      drive_tick(dir_ticks[i].rows);
    end

    for (int p = 0; p < N_PH; p++) begin
      drain_scans();
      write_cfg(CFG_SETTLE, CFG_W'(ph_settle[p]));
      write_cfg(CFG_DEBOUNCE, CFG_W'(ph_bounce[p]));
      idle_on = !(p == 3 || p == N_PH - 1);
      hold_req = (p == 0);
      if (ph_ticks[p] == 0) begin
        key_press(1'b1, 1'b0);
      end else begin
        start = ticks_sent;
        while (ticks_sent - start < ph_ticks[p]) key_press(1'b0, 1'b1);
      end
    end

    drain_scans();
    repeat (8) @(posedge clk);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/kpde_pkg.sv
rtl/keypad_scan_decimal_entry_unit.sv
tb/sv/keypad_scan_decimal_entry_unit_tb.sv
